// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/wds_pkg.sv =====
// ----------------------------------------------------------------------------
// wds_pkg
// Shared constants and types for the wake deadline scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wds_pkg;

    localparam int DEF_TICK_BITS = 32;
    localparam int FIELD_W       = 32;
    localparam int INTERVAL_W    = 31;
    localparam int CMP_W         = 64;

    localparam int NUM_CNT       = 8;
    localparam int CNT_W         = 32;
    localparam int CNT_IDX_W     = 3;

    localparam int ACTION_W      = 3;
    localparam int CFG_ADDR_W    = 2;

    localparam int IN_DATA_W     = 104;
    localparam int OUT_DATA_W    = 136;

    // actions
    localparam logic [ACTION_W-1:0] ACT_RECORD  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PREPARE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_FINISH  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SHORTEN = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_QUERY   = 3'd4;

    // config register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_NORMAL  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WARNING = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RETRY   = 2'd2;

    localparam logic [INTERVAL_W-1:0] NORMAL_RST  = 31'd60000;
    localparam logic [INTERVAL_W-1:0] WARNING_RST = 31'd10000;
    localparam logic [INTERVAL_W-1:0] RETRY_RST   = 31'd5000;

    // statistic counter slots
    localparam logic [CNT_IDX_W-1:0] CNT_ATTEMPTS      = 3'd0;
    localparam logic [CNT_IDX_W-1:0] CNT_SUCCESSES     = 3'd1;
    localparam logic [CNT_IDX_W-1:0] CNT_FAILURES      = 3'd2;
    localparam logic [CNT_IDX_W-1:0] CNT_DUE_CHECKS    = 3'd3;
    localparam logic [CNT_IDX_W-1:0] CNT_DUE_SUCCESSES = 3'd4;
    localparam logic [CNT_IDX_W-1:0] CNT_DUE_WAKES     = 3'd5;
    localparam logic [CNT_IDX_W-1:0] CNT_CLOCK_FAILS   = 3'd6;
    localparam logic [CNT_IDX_W-1:0] CNT_SHORTENS      = 3'd7;

    typedef struct packed {
        logic dl_armed;
        logic pending;
        logic tracking;
        logic last_ok;
    } sched_flags_t;

    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic [FIELD_W-1:0]    now_tick;
        logic                  meas_good;
        logic                  low_warning;
        logic [FIELD_W-1:0]    elapsed;
        logic                  clock_good;
        logic [FIELD_W-1:0]    shorten_by;
    } sched_item_t;

endpackage

`default_nettype wire

// ===== src/wds_step.sv =====
// ----------------------------------------------------------------------------
// wds_step
// Next-state logic for one scheduler event.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wds_step
    import wds_pkg::*;
#(
    parameter int TICK_BITS = DEF_TICK_BITS
)
(
    input  wire sched_item_t             item,
    input  wire logic [INTERVAL_W-1:0]   normal_interval,
    input  wire logic [INTERVAL_W-1:0]   warning_interval,
    input  wire logic [INTERVAL_W-1:0]   retry_interval,
    input  wire logic [TICK_BITS-1:0]    deadline_cur,
    input  wire sched_flags_t            flags_cur,
    input  wire logic [INTERVAL_W-1:0]   sleep_rem_cur,
    input  wire logic [FIELD_W-1:0]      last_elapsed_cur,
    output logic [TICK_BITS-1:0]         deadline_next,
    output sched_flags_t                 flags_next,
    output logic [INTERVAL_W-1:0]        sleep_rem_next,
    output logic [FIELD_W-1:0]           last_elapsed_next,
    output logic [INTERVAL_W-1:0]        remaining,
    output logic [NUM_CNT-1:0]           bump
);

    localparam logic [CMP_W-1:0] HALF_RANGE = (CMP_W'(1) << (TICK_BITS - 1)) - CMP_W'(1);

    logic [TICK_BITS-1:0]  now_t;
    logic [TICK_BITS-1:0]  rem_raw;
    logic [TICK_BITS-1:0]  rem_eval;
    logic                  cfg_ok;
    logic                  eval_fail;
    logic                  pend_eval;
    logic [INTERVAL_W-1:0] next_iv;
    logic                  cut_retry;
    logic [TICK_BITS-1:0]  step_ticks;
    logic                  late_wake;
    logic                  do_shorten;

    assign now_t   = TICK_BITS'(item.now_tick);
    assign rem_raw = deadline_cur - now_t;

    assign cfg_ok = (normal_interval != '0)
                 && (CMP_W'(normal_interval) <= HALF_RANGE)
                 && (warning_interval != '0) && (warning_interval <= normal_interval)
                 && (retry_interval != '0) && (retry_interval <= normal_interval);

    // out of range when half the tick range or more ahead
    assign eval_fail = !cfg_ok || !flags_cur.dl_armed || flags_cur.pending
                    || (rem_raw == '0) || rem_raw[TICK_BITS-1];
    assign rem_eval  = eval_fail ? '0 : rem_raw;
    assign pend_eval = flags_cur.pending || eval_fail;

    assign next_iv    = item.meas_good ? (item.low_warning ? warning_interval : normal_interval)
                                       : retry_interval;
    // failed sample never pushes out an earlier deadline
    assign cut_retry  = !item.meas_good && (rem_eval != '0)
                     && (CMP_W'(rem_eval) < CMP_W'(retry_interval));
    assign step_ticks = cut_retry ? rem_eval : TICK_BITS'(next_iv);

    assign late_wake  = !item.clock_good || (item.elapsed >= FIELD_W'(sleep_rem_cur));
    assign do_shorten = (item.shorten_by != '0)
                     && (CMP_W'(item.shorten_by) < CMP_W'(rem_eval));

    always_comb
    begin
        deadline_next     = deadline_cur;
        flags_next        = flags_cur;
        sleep_rem_next    = sleep_rem_cur;
        last_elapsed_next = last_elapsed_cur;
        remaining         = '0;
        bump              = '0;
        case (item.action)
            ACT_RECORD:
            begin
                if (cfg_ok)
                begin
                    remaining                   = INTERVAL_W'(rem_eval);
                    bump[CNT_DUE_CHECKS]        = pend_eval;
                    bump[CNT_DUE_SUCCESSES]     = pend_eval && item.meas_good;
                    bump[CNT_ATTEMPTS]          = 1'b1;
                    bump[CNT_SUCCESSES]         = item.meas_good;
                    bump[CNT_FAILURES]          = !item.meas_good;
                    flags_next.last_ok          = item.meas_good;
                    flags_next.dl_armed         = 1'b1;
                    flags_next.pending          = 1'b0;
                    deadline_next               = now_t + step_ticks;
                end
            end
            ACT_PREPARE:
            begin
                remaining           = INTERVAL_W'(rem_eval);
                flags_next.pending  = pend_eval;
                sleep_rem_next      = INTERVAL_W'(rem_eval);
                flags_next.tracking = (INTERVAL_W'(rem_eval) != '0);
            end
            ACT_FINISH:
            begin
                if (flags_cur.tracking)
                begin
                    flags_next.tracking = 1'b0;
                    last_elapsed_next   = item.elapsed;
                    if (late_wake)
                    begin
                        deadline_next          = now_t;
                        flags_next.pending     = 1'b1;
                        bump[CNT_DUE_WAKES]    = 1'b1;
                        bump[CNT_CLOCK_FAILS]  = !item.clock_good;
                    end
                    else
                    begin
                        deadline_next = now_t + TICK_BITS'(sleep_rem_cur)
                                      - TICK_BITS'(item.elapsed);
                    end
                end
            end
            ACT_SHORTEN:
            begin
                remaining          = INTERVAL_W'(rem_eval);
                flags_next.pending = pend_eval;
                if (do_shorten)
                begin
                    deadline_next       = now_t + TICK_BITS'(item.shorten_by);
                    bump[CNT_SHORTENS]  = 1'b1;
                end
            end
            ACT_QUERY:
            begin
                remaining          = INTERVAL_W'(rem_eval);
                flags_next.pending = pend_eval;
            end
            default:
            begin
                remaining = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/wds_stats.sv =====
// ----------------------------------------------------------------------------
// wds_stats
// Bank of eight wrapping statistic counters with post-update readout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wds_stats
    import wds_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic [NUM_CNT-1:0]   bump,
    input  wire logic [CNT_IDX_W-1:0] sel,
    output logic [CNT_W-1:0]          value
);

    logic [CNT_W-1:0] cnt_reg  [NUM_CNT];
    logic [CNT_W-1:0] cnt_next [NUM_CNT];

    always_comb
    begin
        for (int i = 0; i < NUM_CNT; i++)
        begin
            cnt_next[i] = cnt_reg[i] + CNT_W'(bump[i]);
        end
    end

    assign value = cnt_next[sel];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CNT; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            for (int i = 0; i < NUM_CNT; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/wake_deadline_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// wake_deadline_scheduler_core
// Wrap-safe wake deadline scheduler for periodic battery sampling.
//
//   channel  dir  payload
//   s_*      in   tuser: action; tdata: now_tick, meas_good, low_warning,
//                 elapsed, clock_good, shorten_by, counter_index
//   m_*      out  tdata: remaining, deadline, due_pending, deadline_set,
//                 sleep_tracking, last_ok, last_elapsed, counter_value
//   cfg_*    in   normal, warning, retry interval writes
//
// One item per cycle sustained while m_tready keeps the result moving; an accepted
// item passes the input register, then the event logic into the result register.
// The event logic reads and updates the scheduler state in the same cycle.
// A stalled result holds the next item in the input register and drops s_tready.
// Reset clears all state, counters and valid flags; intervals return to defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module wake_deadline_scheduler_core
    import wds_pkg::*;
#(
    parameter int TICK_BITS = DEF_TICK_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [31:0] now_tick, [32] meas_good, [33] low_warning, [65:34] elapsed,
    // [66] clock_good, [98:67] shorten_by, [101:99] counter_index
    input  wire logic [IN_DATA_W-1:0]   s_tdata,
    // [2:0] action
    input  wire logic [ACTION_W-1:0]    s_tuser,

    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [30:0] remaining, [62:31] deadline, [63] due_pending, [64] deadline_set,
    // [65] sleep_tracking, [66] last_ok, [98:67] last_elapsed,
    // [130:99] counter_value
    output logic [OUT_DATA_W-1:0]       m_tdata,

    input  wire logic                   cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [INTERVAL_W-1:0]  cfg_wdata
);

    logic                  in_valid_reg;
    logic [ACTION_W-1:0]   in_action_reg;
    logic [IN_DATA_W-1:0]  in_data_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;
    logic                  advance;

    logic [INTERVAL_W-1:0] normal_reg;
    logic [INTERVAL_W-1:0] warning_reg;
    logic [INTERVAL_W-1:0] retry_reg;

    logic [TICK_BITS-1:0]  deadline_reg;
    logic [TICK_BITS-1:0]  deadline_next;
    sched_flags_t          flags_reg;
    sched_flags_t          flags_next;
    logic [INTERVAL_W-1:0] sleep_rem_reg;
    logic [INTERVAL_W-1:0] sleep_rem_next;
    logic [FIELD_W-1:0]    last_elapsed_reg;
    logic [FIELD_W-1:0]    last_elapsed_next;

    sched_item_t           item;
    logic [CNT_IDX_W-1:0]  cnt_sel;
    logic [INTERVAL_W-1:0] remaining;
    logic [NUM_CNT-1:0]    bump;
    logic [CNT_W-1:0]      counter_value;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign item.action      = in_action_reg;
    assign item.now_tick    = in_data_reg[31:0];
    assign item.meas_good   = in_data_reg[32];
    assign item.low_warning = in_data_reg[33];
    assign item.elapsed     = in_data_reg[65:34];
    assign item.clock_good  = in_data_reg[66];
    assign item.shorten_by  = in_data_reg[98:67];
    assign cnt_sel          = in_data_reg[101:99];

    wds_step #(
        .TICK_BITS (TICK_BITS)
    ) u_step (
        .item              (item),
        .normal_interval   (normal_reg),
        .warning_interval  (warning_reg),
        .retry_interval    (retry_reg),
        .deadline_cur      (deadline_reg),
        .flags_cur         (flags_reg),
        .sleep_rem_cur     (sleep_rem_reg),
        .last_elapsed_cur  (last_elapsed_reg),
        .deadline_next     (deadline_next),
        .flags_next        (flags_next),
        .sleep_rem_next    (sleep_rem_next),
        .last_elapsed_next (last_elapsed_next),
        .remaining         (remaining),
        .bump              (bump)
    );

    wds_stats u_stats (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .bump  (bump),
        .sel   (cnt_sel),
        .value (counter_value)
    );

    assign out_data_next = {5'b0, counter_value, last_elapsed_next, flags_next.last_ok,
                            flags_next.tracking, flags_next.dl_armed,
                            flags_next.pending, FIELD_W'(deadline_next), remaining};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_action_reg <= s_tuser;
            in_data_reg   <= s_tdata;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_reg  <= NORMAL_RST;
            warning_reg <= WARNING_RST;
            retry_reg   <= RETRY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_NORMAL:  normal_reg  <= cfg_wdata;
                REG_WARNING: warning_reg <= cfg_wdata;
                REG_RETRY:   retry_reg   <= cfg_wdata;
                default:     normal_reg  <= normal_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadline_reg     <= '0;
            flags_reg        <= '0;
            sleep_rem_reg    <= '0;
            last_elapsed_reg <= '0;
        end
        else if (advance)
        begin
            deadline_reg     <= deadline_next;
            flags_reg        <= flags_next;
            sleep_rem_reg    <= sleep_rem_next;
            last_elapsed_reg <= last_elapsed_next;
        end
    end

    `ASSERT_CLK(a_track_nonzero, flags_reg.tracking |-> (sleep_rem_reg != '0), "tracking with zero stored remaining")
    `ASSERT_CLK(a_deadline_sticky, !$fell(flags_reg.dl_armed), "deadline flag dropped")
    `ASSERT_CLK(a_state_hold, !advance |=> $stable(deadline_reg) && $stable(flags_reg), "state changed without an item")
    `ASSERT_ALWAYS(a_adv_needs_item, advance |-> in_valid_reg, "advance without a held item")

endmodule

`default_nettype wire
